>>> rtl/assert_macros.svh
// Shared assertion macros. The including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hss_pkg.sv
`timescale 1ns / 1ps
package hss_pkg;

  localparam int unsigned ID_W       = 4;
  localparam int unsigned SCORE_W    = 32;
  localparam int unsigned SUM_W      = SCORE_W + 2;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned COOL_W     = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COOLDOWN = 1'b0,
    CFG_MARGIN   = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RSN_NONE_VALID  = 3'd0,
    RSN_INITIAL     = 3'd1,
    RSN_INC_INVALID = 3'd2,
    RSN_HOLD        = 3'd3,
    RSN_COOLDOWN    = 3'd4,
    RSN_MARGIN      = 3'd5,
    RSN_SWITCHED    = 3'd6
  } reason_t;

  // End-of-round summary handed from the front tracker to the decision unit.
  typedef struct packed {
    logic                      best_found;
    logic [ID_W-1:0]           best_src;
    logic signed [SCORE_W-1:0] best_score;
    logic                      second_found;
    logic [ID_W-1:0]           second_src;
    logic                      inc_seen;
    logic                      inc_valid;
    logic signed [SCORE_W-1:0] inc_score;
    logic [TIME_W-1:0]         now;
  } hss_summary_t;

  typedef struct packed {
    logic            has_current;
    logic [ID_W-1:0] current_source;
  } hss_cur_t;

  typedef struct packed {
    logic            sel_active;
    logic [ID_W-1:0] selected_id;
    reason_t         reason_code;
    logic            switched;
    logic            alt_found;
    logic [ID_W-1:0] runner_up_id;
  } hss_result_t;

endpackage

>>> rtl/hss_ifs.sv
`timescale 1ns / 1ps
interface hss_in_if;
  import hss_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ID_W-1:0]           source_id;
  logic                      source_valid;
  logic signed [SCORE_W-1:0] source_score;
  logic [TIME_W-1:0]         now_ticks;
  logic                      last_source;

  modport source (
    output valid, source_id, source_valid, source_score, now_ticks, last_source,
    input  ready
  );
  modport sink (
    input  valid, source_id, source_valid, source_score, now_ticks, last_source,
    output ready
  );
endinterface

interface hss_out_if;
  import hss_pkg::*;

  logic            valid;
  logic            ready;
  logic            sel_active;
  logic [ID_W-1:0] selected_id;
  logic [2:0]      reason_code;
  logic            switched;
  logic            alt_found;
  logic [ID_W-1:0] runner_up_id;

  modport source (
    output valid, sel_active, selected_id, reason_code, switched, alt_found,
           runner_up_id,
    input  ready
  );
  modport sink (
    input  valid, sel_active, selected_id, reason_code, switched, alt_found,
           runner_up_id,
    output ready
  );
endinterface

>>> rtl/hss_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hss_front (
  input  logic                             clk,
  input  logic                             rst_n,
  hss_in_if.sink                           in_ch,
  input  hss_pkg::hss_cur_t                cur_i,
  input  logic [hss_pkg::FIFO_CNT_W-1:0]   fifo_count_i,
  output hss_pkg::hss_summary_t            summary_o,
  output logic                             summary_v_o
);
  import hss_pkg::*;

  localparam int unsigned LVL_W = FIFO_CNT_W + 1;

  logic                      best_found_r, best_found_nxt;
  logic [ID_W-1:0]           best_src_r, best_src_nxt;
  logic signed [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic                      second_found_r, second_found_nxt;
  logic [ID_W-1:0]           second_src_r, second_src_nxt;
  logic signed [SCORE_W-1:0] second_score_r, second_score_nxt;
  logic                      inc_seen_r, inc_seen_nxt;
  logic                      inc_valid_r, inc_valid_nxt;
  logic signed [SCORE_W-1:0] inc_score_r, inc_score_nxt;
  logic                      summary_v_r;
  hss_summary_t              summary_r, summary_nxt;
  logic [LVL_W-1:0]          level;
  logic                      acc;
  logic                      inc_hit;

  // Every word taken may close a round, so keep a queue slot free for it,
  // counting the summary that has not reached the queue yet.
  assign level       = LVL_W'(fifo_count_i) + LVL_W'(summary_v_r);
  assign in_ch.ready = (level < LVL_W'(FIFO_DEPTH));
  assign acc         = in_ch.valid & in_ch.ready;

  // cur_i already reflects a decision resolving in this same cycle.
  assign inc_hit = cur_i.has_current && !inc_seen_r &&
                   (in_ch.source_id == cur_i.current_source);

  always_comb begin
    best_found_nxt   = best_found_r;
    best_src_nxt     = best_src_r;
    best_score_nxt   = best_score_r;
    second_found_nxt = second_found_r;
    second_src_nxt   = second_src_r;
    second_score_nxt = second_score_r;
    inc_seen_nxt     = inc_seen_r;
    inc_valid_nxt    = inc_valid_r;
    inc_score_nxt    = inc_score_r;
    if (inc_hit) begin
      inc_seen_nxt  = 1'b1;
      inc_valid_nxt = in_ch.source_valid;
      inc_score_nxt = in_ch.source_score;
    end
    if (in_ch.source_valid) begin
      if (!best_found_r || (in_ch.source_score > best_score_r)) begin
        second_found_nxt = best_found_r;
        second_src_nxt   = best_src_r;
        second_score_nxt = best_score_r;
        best_found_nxt   = 1'b1;
        best_src_nxt     = in_ch.source_id;
        best_score_nxt   = in_ch.source_score;
      end else if (!second_found_r || (in_ch.source_score > second_score_r)) begin
        second_found_nxt = 1'b1;
        second_src_nxt   = in_ch.source_id;
        second_score_nxt = in_ch.source_score;
      end
    end
    summary_nxt.best_found   = best_found_nxt;
    summary_nxt.best_src     = best_src_nxt;
    summary_nxt.best_score   = best_score_nxt;
    summary_nxt.second_found = second_found_nxt;
    summary_nxt.second_src   = second_src_nxt;
    summary_nxt.inc_seen     = inc_seen_nxt;
    summary_nxt.inc_valid    = inc_valid_nxt;
    summary_nxt.inc_score    = inc_score_nxt;
    summary_nxt.now          = in_ch.now_ticks;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r   <= 1'b0;
      second_found_r <= 1'b0;
      inc_seen_r     <= 1'b0;
      inc_valid_r    <= 1'b0;
      summary_v_r    <= 1'b0;
    end else begin
      summary_v_r <= acc & in_ch.last_source;
      if (acc) begin
        if (in_ch.last_source) begin
          best_found_r   <= 1'b0;
          second_found_r <= 1'b0;
          inc_seen_r     <= 1'b0;
          inc_valid_r    <= 1'b0;
        end else begin
          best_found_r   <= best_found_nxt;
          second_found_r <= second_found_nxt;
          inc_seen_r     <= inc_seen_nxt;
          inc_valid_r    <= inc_valid_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      best_src_r     <= best_src_nxt;
      best_score_r   <= best_score_nxt;
      second_src_r   <= second_src_nxt;
      second_score_r <= second_score_nxt;
      inc_score_r    <= inc_score_nxt;
      if (in_ch.last_source) begin
        summary_r <= summary_nxt;
      end
    end
  end

  assign summary_o   = summary_r;
  assign summary_v_o = summary_v_r;

  `HSS_ASSERT_NOW(a_round_cleared, summary_v_r, !best_found_r && !inc_seen_r,
    "round trackers not cleared after the closing word")
  `HSS_ASSERT_NOW(a_second_needs_best, second_found_r, best_found_r,
    "runner-up tracked without a best source")

endmodule

>>> rtl/hss_decide.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hss_decide (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hss_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  hss_pkg::hss_summary_t            summary_i,
  input  logic                             summary_v_i,
  output hss_pkg::hss_cur_t                cur_o,
  output hss_pkg::hss_result_t             result_o,
  output logic                             result_v_o
);
  import hss_pkg::*;

  logic [COOL_W-1:0]         cooldown_r;
  logic signed [SCORE_W-1:0] margin_r;
  logic [ID_W-1:0]           current_source_r, current_source_nxt;
  logic                      has_current_r, has_current_nxt;
  logic [TIME_W-1:0]         last_switch_time_r, last_switch_time_nxt;
  logic                      has_switched_once_r, has_switched_once_nxt;

  logic [TIME_W-1:0]         held;
  logic                      cool_hold;
  logic signed [SCORE_W-1:0] inc_score;
  logic signed [SCORE_W-1:0] best_score;
  logic signed [SUM_W-1:0]   need_sum;
  logic signed [SUM_W-1:0]   best_ext;
  logic                      margin_short;
  logic                      commit;
  hss_result_t               res;

  assign held      = summary_i.now - last_switch_time_r;
  assign cool_hold = has_switched_once_r && (cooldown_r != '0) &&
                     (held < TIME_W'(cooldown_r));

  // Incumbent plus margin is formed at full width so it cannot wrap.
  assign inc_score    = summary_i.inc_score;
  assign best_score   = summary_i.best_score;
  assign need_sum     = SUM_W'(inc_score) + SUM_W'(margin_r);
  assign best_ext     = SUM_W'(best_score);
  assign margin_short = (best_ext < need_sum);

  always_comb begin
    current_source_nxt    = current_source_r;
    has_current_nxt       = has_current_r;
    last_switch_time_nxt  = last_switch_time_r;
    has_switched_once_nxt = has_switched_once_r;
    commit                = 1'b0;
    res.sel_active        = 1'b0;
    res.selected_id       = '0;
    res.reason_code       = RSN_NONE_VALID;
    res.switched          = 1'b0;
    res.alt_found         = summary_i.second_found;
    res.runner_up_id      = summary_i.second_found ? summary_i.second_src : '0;
    if (summary_v_i) begin
      if (!summary_i.best_found) begin
        has_current_nxt    = 1'b0;
        current_source_nxt = '0;
      end else if (!(summary_i.inc_seen && summary_i.inc_valid)) begin
        res.reason_code = has_current_r ? RSN_INC_INVALID : RSN_INITIAL;
        commit          = 1'b1;
      end else if (summary_i.best_src == current_source_r) begin
        res.sel_active  = 1'b1;
        res.selected_id = current_source_r;
        res.reason_code = RSN_HOLD;
      end else if (cool_hold) begin
        res.sel_active  = 1'b1;
        res.selected_id = current_source_r;
        res.reason_code = RSN_COOLDOWN;
      end else if (margin_short) begin
        res.sel_active  = 1'b1;
        res.selected_id = current_source_r;
        res.reason_code = RSN_MARGIN;
      end else begin
        res.reason_code = RSN_SWITCHED;
        commit          = 1'b1;
      end
      if (commit) begin
        res.sel_active  = 1'b1;
        res.selected_id = summary_i.best_src;
        // Recommitting to the same source is not a switch.
        if (!has_current_r || (current_source_r != summary_i.best_src)) begin
          res.switched          = 1'b1;
          current_source_nxt    = summary_i.best_src;
          has_current_nxt       = 1'b1;
          last_switch_time_nxt  = summary_i.now;
          has_switched_once_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooldown_r          <= '0;
      margin_r            <= '0;
      current_source_r    <= '0;
      has_current_r       <= 1'b0;
      last_switch_time_r  <= '0;
      has_switched_once_r <= 1'b0;
    end else begin
      current_source_r    <= current_source_nxt;
      has_current_r       <= has_current_nxt;
      last_switch_time_r  <= last_switch_time_nxt;
      has_switched_once_r <= has_switched_once_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_COOLDOWN: cooldown_r <= COOL_W'(cfg_data);
          CFG_MARGIN:   margin_r   <= SCORE_W'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  assign cur_o.has_current    = has_current_nxt;
  assign cur_o.current_source = current_source_nxt;
  assign result_o             = res;
  assign result_v_o           = summary_v_i;

  `HSS_ASSERT_NEXT(a_switch_takes, summary_v_i && res.switched,
    has_current_r && (current_source_r == $past(res.selected_id)),
    "switch decision did not update the incumbent")
  `HSS_ASSERT_NEXT(a_none_clears, summary_v_i && !summary_i.best_found,
    !has_current_r && !$past(res.sel_active),
    "round without valid sources left a selection")

endmodule

>>> rtl/hss_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hss_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push_i,
  input  hss_pkg::hss_result_t             push_data_i,
  hss_out_if.source                        out_ch,
  output logic [hss_pkg::FIFO_CNT_W-1:0]   count_o
);
  import hss_pkg::*;

  hss_result_t            mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_r;
  logic [FIFO_PTR_W-1:0]  rd_ptr_r;
  logic [FIFO_CNT_W-1:0]  count_r, count_nxt;
  logic                   pop;
  hss_result_t            head;

  assign head = mem_r[rd_ptr_r];
  assign pop  = out_ch.valid & out_ch.ready;

  always_comb begin
    count_nxt = count_r;
    if (push_i && !pop) begin
      count_nxt = count_r + FIFO_CNT_W'(1);
    end else if (!push_i && pop) begin
      count_nxt = count_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  assign out_ch.valid        = (count_r != '0);
  assign out_ch.sel_active   = head.sel_active;
  assign out_ch.selected_id  = head.selected_id;
  assign out_ch.reason_code  = head.reason_code;
  assign out_ch.switched     = head.switched;
  assign out_ch.alt_found    = head.alt_found;
  assign out_ch.runner_up_id = head.runner_up_id;
  assign count_o             = count_r;

  `HSS_ASSERT_NOW(a_no_overflow, push_i,
    (count_r < FIFO_CNT_W'(FIFO_DEPTH)) || pop,
    "result queue written while full")

endmodule

>>> rtl/hysteresis_source_selector_top.sv
// A round's closing word accepted on in_ch is registered in the round tracker; its decision
// is then written to a four-entry result queue that drives out_ch and absorbs output stalls.
// Throughput: one input word per cycle while the result queue has room; the decision for one
// round is resolved in time for the next round's first word.
// Reset: synchronous, active-low rst_n clears the incumbent, round trackers, queue and
// both configuration registers; the block is ready the cycle after reset is released.
`timescale 1ns / 1ps
module hysteresis_source_selector_top (
  input  logic                             clk,
  input  logic                             rst_n,
  hss_in_if.sink                           in_ch,
  hss_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [hss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hss_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hss_pkg::*;

  hss_summary_t          summary;
  logic                  summary_v;
  hss_cur_t              cur;
  hss_result_t           result;
  logic                  result_v;
  logic [FIFO_CNT_W-1:0] fifo_count;

  hss_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .cur_i        (cur),
    .fifo_count_i (fifo_count),
    .summary_o    (summary),
    .summary_v_o  (summary_v)
  );

  hss_decide u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .summary_i   (summary),
    .summary_v_i (summary_v),
    .cur_o       (cur),
    .result_o    (result),
    .result_v_o  (result_v)
  );

  hss_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (result_v),
    .push_data_i (result),
    .out_ch      (out_ch),
    .count_o     (fifo_count)
  );

endmodule
